// ----- sv/mccl_pkg.sv -----
package mccl_pkg;

  // Slot count of the learn table. The slot field on the result side is
  // three bits wide, so the table holds at most eight slots.
  localparam int NUM_SLOTS = 8;

  localparam int SLOT_W   = 3;
  localparam int CTRL_W   = 7;
  localparam int CHAN_W   = 4;
  localparam int VAL_W    = 7;
  localparam int STATUS_W = 8;
  localparam int CNT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Upper nibble of a control-change status byte.
  localparam logic [3:0] CC_CODE = 4'hB;

  // Value bytes are centered on 64.
  localparam logic [VAL_W-1:0] VALUE_OFFSET = 7'd64;

  // Input command codes.
  localparam logic CMD_MSG   = 1'b0;
  localparam logic CMD_LEARN = 1'b1;

  typedef struct packed {
    logic [CTRL_W-1:0] ctrl;
    logic [CHAN_W-1:0] chan;
  } key_t;

  typedef struct packed {
    logic vld;
    key_t key;
  } tok_t;

  typedef logic [NUM_SLOTS-1:0] slot_vec_t;

  typedef struct packed {
    slot_vec_t wr_en;
    slot_vec_t hit_clr;
  } chain_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_LEARN
  } state_t;

  // Index of the lowest set bit.
  function automatic logic [SLOT_W-1:0] first_hit(slot_vec_t v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  // One-hot mask of the lowest set bit.
  function automatic slot_vec_t lowest_bit(slot_vec_t v);
    return v & (~v + slot_vec_t'(1));
  endfunction

endpackage

// ----- sv/midi_cc_learn_demux.sv -----
// A learning message gives its one word in the cycle after it is taken; a matching message
// gives its first word once its key has passed every cell, then one word a cycle while
// out_stall is low. No new message is taken while a control change is scanned or its words
// are given, or while a learn capture's word waits; learn requests and other statuses can be
// taken one a cycle.
// Reset (rst_n low, synchronous) empties all slots and disarms learning.
module midi_cc_learn_demux (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [mccl_pkg::STATUS_W-1:0]     in_status_byte,
  input  logic [mccl_pkg::CTRL_W-1:0]       in_controller_number,
  input  logic [mccl_pkg::VAL_W-1:0]        in_value_byte,
  input  logic [mccl_pkg::SLOT_W-1:0]       in_learn_slot,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mccl_pkg::SLOT_W-1:0]       out_slot,
  output logic signed [mccl_pkg::VAL_W-1:0] out_value,
  output logic                              out_last
);
  import mccl_pkg::*;

  // The slot table is a row of cells. Each cell owns one slot's key
  // (controller and channel) and its valid flag. A control-change key
  // is launched into the first cell and moves one cell per cycle; each
  // cell compares it against its own key as it passes and keeps a hit
  // flag. Once the key has left the last cell, the controller walks the
  // hit flags from the lowest slot up, giving one word per cycle while
  // out_stall is low and clearing each hit as its word is taken. The last
  // flag is set when no hit above the current one remains.
  //
  // A learn capture bypasses the row: the armed cell is written on the
  // edge that takes the message, and a single word follows.

  key_t       in_key;
  tok_t       chain [NUM_SLOTS];
  slot_vec_t  hits;
  chain_ctl_t ctl;

  assign in_key = '{ctrl: in_controller_number,
                    chan: in_status_byte[CHAN_W-1:0]};

  mccl_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_status_byte (in_status_byte),
    .in_key         (in_key),
    .in_value_byte  (in_value_byte),
    .in_learn_slot  (in_learn_slot),
    .hits           (hits),
    .tok_o          (chain[0]),
    .ctl            (ctl),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot       (out_slot),
    .out_value      (out_value),
    .out_last       (out_last)
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    if (i < NUM_SLOTS - 1) begin : g_mid
      mccl_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_i   (chain[i]),
        .tok_o   (chain[i+1]),
        .wr_en   (ctl.wr_en[i]),
        .wr_key  (in_key),
        .hit_clr (ctl.hit_clr[i]),
        .hit_o   (hits[i])
      );
    end else begin : g_end
      // The key leaving the last cell goes nowhere.
      mccl_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_i   (chain[i]),
        .tok_o   (),
        .wr_en   (ctl.wr_en[i]),
        .wr_key  (in_key),
        .hit_clr (ctl.hit_clr[i]),
        .hit_o   (hits[i])
      );
    end
  end

endmodule

// ----- sv/mccl_cell.sv -----
module mccl_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  mccl_pkg::tok_t  tok_i,
  output mccl_pkg::tok_t  tok_o,
  input  logic            wr_en,
  input  mccl_pkg::key_t  wr_key,
  input  logic            hit_clr,
  output logic            hit_o
);
  import mccl_pkg::*;

  key_t key_r;
  key_t tok_key_r;
  logic valid_r;
  logic hit_r;
  logic tok_vld_r;
  logic match;

  // An empty slot never matches, whatever its key register holds.
  assign match = tok_i.vld && valid_r && (tok_i.key == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      hit_r     <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r <= 1'b1;
      end
      tok_vld_r <= tok_i.vld;
      if (match) begin
        hit_r <= 1'b1;
      end else if (hit_clr) begin
        hit_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r <= wr_key;
    end
    tok_key_r <= tok_i.key;
  end

  assign tok_o = '{vld: tok_vld_r, key: tok_key_r};
  assign hit_o = hit_r;

endmodule

// ----- sv/mccl_ctrl.sv -----
module mccl_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic [mccl_pkg::STATUS_W-1:0]    in_status_byte,
  input  mccl_pkg::key_t                   in_key,
  input  logic [mccl_pkg::VAL_W-1:0]       in_value_byte,
  input  logic [mccl_pkg::SLOT_W-1:0]      in_learn_slot,
  input  mccl_pkg::slot_vec_t              hits,
  output mccl_pkg::tok_t                   tok_o,
  output mccl_pkg::chain_ctl_t             ctl,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mccl_pkg::SLOT_W-1:0]      out_slot,
  output logic signed [mccl_pkg::VAL_W-1:0] out_value,
  output logic                             out_last
);
  import mccl_pkg::*;

  state_t             state_r;
  state_t             state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               armed_r;
  logic [SLOT_W-1:0]  armed_slot_r;
  logic [VAL_W-1:0]   value_r;
  logic               tok_vld_r;
  key_t               tok_key_r;

  logic               accept;
  logic               is_cc;
  logic               msg_cc;
  logic               learn_wr;
  logic               scan_go;
  logic               out_fire;
  logic [SLOT_W-1:0]  lslot;
  slot_vec_t          hits_low;
  slot_vec_t          hits_rest;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign is_cc     = (in_status_byte[STATUS_W-1:STATUS_W-4] == CC_CODE);
  assign msg_cc    = accept && (in_command == CMD_MSG) && is_cc;
  assign learn_wr  = msg_cc && armed_r;
  assign scan_go   = msg_cc && !armed_r;
  assign out_fire  = out_valid && !out_stall;
  assign hits_low  = lowest_bit(hits);
  assign hits_rest = hits & ~hits_low;
  assign lslot     = (in_learn_slot > SLOT_W'(NUM_SLOTS - 1)) ?
                     SLOT_W'(NUM_SLOTS - 1) : in_learn_slot;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (learn_wr) begin
          state_nxt = ST_LEARN;
        end else if (scan_go) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == CNT_W'(NUM_SLOTS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (hits == '0) begin
          state_nxt = ST_IDLE;
        end else if (out_fire && (hits_rest == '0)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LEARN: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    out_valid   = 1'b0;
    out_slot    = first_hit(hits);
    out_last    = (hits_rest == '0);
    ctl.hit_clr = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ctl.wr_en[i] = learn_wr && (armed_slot_r == SLOT_W'(i));
    end
    case (state_r)
      ST_EMIT: begin
        out_valid = (hits != '0);
        if (out_fire) begin
          ctl.hit_clr = hits_low;
        end
      end
      ST_LEARN: begin
        out_valid = 1'b1;
        out_slot  = armed_slot_r;
        out_last  = 1'b1;
      end
      default: begin
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      armed_r      <= 1'b0;
      armed_slot_r <= '0;
      tok_vld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tok_vld_r <= scan_go;
      if (scan_go) begin
        cnt_r <= '0;
      end else if (state_r == ST_SCAN) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (accept && (in_command == CMD_LEARN)) begin
        armed_r      <= 1'b1;
        armed_slot_r <= lslot;
      end else if (learn_wr) begin
        armed_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg_cc) begin
      value_r <= in_value_byte - VALUE_OFFSET;
    end
    if (scan_go) begin
      tok_key_r <= in_key;
    end
  end

  assign tok_o     = '{vld: tok_vld_r, key: tok_key_r};
  assign out_value = value_r;

endmodule

// ----- sv/mccl_chk.sv -----
module mccl_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_command,
  input logic [mccl_pkg::STATUS_W-1:0]     in_status_byte,
  input logic [mccl_pkg::CTRL_W-1:0]       in_controller_number,
  input logic [mccl_pkg::VAL_W-1:0]        in_value_byte,
  input logic [mccl_pkg::SLOT_W-1:0]       in_learn_slot,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [mccl_pkg::SLOT_W-1:0]       out_slot,
  input logic signed [mccl_pkg::VAL_W-1:0] out_value,
  input logic                              out_last
);
  import mccl_pkg::*;

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot) &&
      $stable(out_value) && $stable(out_last))
    else $error("stalled output word changed");

  // No new word is taken while results are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  // A learn request gives no result.
  a_learn_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == CMD_LEARN) |=> !out_valid)
    else $error("learn request produced a result");

  // A status other than control change gives no result.
  a_non_cc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == CMD_MSG) &&
      (in_status_byte[STATUS_W-1:STATUS_W-4] != CC_CODE) |=> !out_valid)
    else $error("non control-change message produced a result");

  // Results of one message come in rising slot order without a gap.
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && (out_slot > $past(out_slot)))
    else $error("result slots out of order");

endmodule

bind midi_cc_learn_demux mccl_chk u_mccl_chk (.*);

// ----- test/tb_midi_cc_learn_demux.sv -----
module tb_midi_cc_learn_demux;
  timeunit 1ns;
  timeprecision 1ps;

  import mccl_pkg::*;

  // Status bytes that are not control changes. The block has to drop them
  // without touching the learn table or the armed slot.
  localparam logic [STATUS_W-1:0] STAT_NOTE_ON    = 8'h90;
  localparam logic [STATUS_W-1:0] STAT_POLY_TOUCH = 8'hA0;
  localparam logic [STATUS_W-1:0] STAT_PROGRAM    = 8'hC0;
  localparam logic [STATUS_W-1:0] STAT_SYS_RESET  = 8'hFF;
  localparam logic [STATUS_W-1:0] STAT_ZERO       = 8'h00;

  // Least number of input words of every kind to generate; the last group may run past it.
  localparam int TARGET_ITEMS = 370;
  // The last items of the run go through without any idling on either side.
  localparam int TAIL_ITEMS = 40;
  // Cycles the receiver holds off once, so that the block backs up into its input.
  localparam int LONG_HOLD = 300;
  // The slowest correct stretch without any handshake is a sender idle
  // burst, the scan of the row, then eight words each stalled by the
  // receiver. The long hold-off adds LONG_HOLD. The limit takes that
  // several times over.
  localparam int WATCHDOG_LIMIT = 2000;

  // One input word as the sender sees it.
  typedef struct packed {
    logic                command;
    logic [STATUS_W-1:0] status;
    logic [CTRL_W-1:0]   ctrl;
    logic [VAL_W-1:0]    vbyte;
    logic [SLOT_W-1:0]   lslot;
  } midi_item_t;

  // One routed controller value as the block should give it.
  typedef struct {
    logic [SLOT_W-1:0]       slot;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } routed_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_command = CMD_MSG;
  logic [STATUS_W-1:0]        in_status_byte = '0;
  logic [CTRL_W-1:0]          in_controller_number = '0;
  logic [VAL_W-1:0]           in_value_byte = '0;
  logic [SLOT_W-1:0]          in_learn_slot = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [SLOT_W-1:0]          out_slot;
  logic signed [VAL_W-1:0]    out_value;
  logic                       out_last;

  midi_cc_learn_demux DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_status_byte       (in_status_byte),
    .in_controller_number (in_controller_number),
    .in_value_byte        (in_value_byte),
    .in_learn_slot        (in_learn_slot),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_slot             (out_slot),
    .out_value            (out_value),
    .out_last             (out_last)
  );

  initial begin
    forever #1ns clk = ~clk;
  end

  // Words waiting to be offered, and the routed words still owed by the block.
  midi_item_t   pending_items[$];
  routed_word_t routed_words[$];
  int           items_total = 0;
  int           items_taken = 0;
  int           counted_items = 0;
  int           mismatches = 0;

  // The predictor's own copy of the learn table and the learn arming.
  logic [CTRL_W-1:0] learned_ctrl[NUM_SLOTS];
  logic [CHAN_W-1:0] learned_chan[NUM_SLOTS];
  logic              learned_used[NUM_SLOTS];
  logic              learning;
  logic [SLOT_W-1:0] learning_slot;

  // Shared pacing flags: calm_window turns idling off for whole stretches,
  // tail_calm turns it off for the end of the run.
  logic       calm_window = 1'b0;
  logic       tail_calm = 1'b0;
  logic [5:0] pace_count = '0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  // Works out what the block owes for one accepted input word and updates
  // the predicted learn table. A learn request only arms a slot. A control
  // change either trains the armed slot (one word, then disarm) or fans out
  // to every valid slot with the same controller and channel, lowest slot
  // first, with last set on the highest one.
  task automatic route_message(input midi_item_t it);
    logic [CHAN_W-1:0]       chan;
    logic signed [VAL_W-1:0] centered;
    logic [NUM_SLOTS-1:0]    hits;
    if (it.command == CMD_LEARN) begin
      learning = 1'b1;
      learning_slot = (it.lslot > NUM_SLOTS - 1) ? SLOT_W'(NUM_SLOTS - 1) : it.lslot;
    end else if (it.status[7:4] == CC_CODE) begin
      chan = it.status[3:0];
      // The data byte recentered on zero, wrapped to seven bits.
      centered = it.vbyte - VALUE_OFFSET;
      if (learning) begin
        learned_ctrl[learning_slot] = it.ctrl;
        learned_chan[learning_slot] = chan;
        learned_used[learning_slot] = 1'b1;
        learning = 1'b0;
        routed_words.push_back('{slot: learning_slot, value: centered, last: 1'b1});
      end else begin
        hits = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          hits[s] = learned_used[s] && learned_ctrl[s] == it.ctrl && learned_chan[s] == chan;
        end
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (hits[s]) begin
            routed_words.push_back('{slot: SLOT_W'(s), value: centered,
                                     last: (hits >> (s + 1)) == '0});
          end
        end
      end
    end
  endtask

  function automatic void queue_item(input midi_item_t it);
    pending_items.push_back(it);
    counted_items++;
  endfunction

  // A learn request; the fields it ignores carry random values.
  function automatic midi_item_t learn_item(input logic [SLOT_W-1:0] slot);
    midi_item_t it;
    it.command = CMD_LEARN;
    it.status  = STATUS_W'($urandom_range(0, 255));
    it.ctrl    = CTRL_W'($urandom_range(0, 127));
    it.vbyte   = VAL_W'($urandom_range(0, 127));
    it.lslot   = slot;
    return it;
  endfunction

  // A MIDI message with any status byte; learn_slot is ignored and random.
  function automatic midi_item_t midi_item(input logic [STATUS_W-1:0] status,
                                           input logic [CTRL_W-1:0] ctrl,
                                           input logic [VAL_W-1:0] vbyte);
    midi_item_t it;
    it.command = CMD_MSG;
    it.status  = status;
    it.ctrl    = ctrl;
    it.vbyte   = vbyte;
    it.lslot   = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    return it;
  endfunction

  function automatic midi_item_t cc_item(input logic [CHAN_W-1:0] chan,
                                         input logic [CTRL_W-1:0] ctrl,
                                         input logic [VAL_W-1:0] vbyte);
    return midi_item({CC_CODE, chan}, ctrl, vbyte);
  endfunction

  // Stimulus, reset and the end of the run.
  initial begin
    logic [CHAN_W-1:0] pool_chan[3];
    logic [CTRL_W-1:0] pool_ctrl[3];
    logic [CHAN_W-1:0] chan;
    logic [CTRL_W-1:0] ctrl;
    int                pick;
    int                roll;

    for (int s = 0; s < NUM_SLOTS; s++) begin
      learned_ctrl[s] = '0;
      learned_chan[s] = '0;
      learned_used[s] = 1'b0;
    end
    learning = 1'b0;
    learning_slot = '0;

    // Directed part. A control change on an empty table gives nothing.
    queue_item(cc_item(4'h0, 7'd0, 7'd0));
    // Train slot 0 with the lowest key and value, slot 7 with the highest.
    queue_item(learn_item(3'd0));
    queue_item(cc_item(4'h0, 7'd0, 7'd0));
    queue_item(learn_item(3'd7));
    queue_item(cc_item(4'hF, 7'd127, 7'd127));
    // A second learn request re-arms another slot, and a note-on in between
    // must leave the arming alone.
    queue_item(learn_item(3'd3));
    queue_item(learn_item(3'd5));
    queue_item(midi_item(STAT_NOTE_ON, 7'd127, 7'd64));
    queue_item(cc_item(4'hF, 7'd127, 7'd64));
    // Slots 5 and 7 now share a key, so one message fans out to both.
    queue_item(cc_item(4'hF, 7'd127, 7'd65));
    queue_item(cc_item(4'h0, 7'd0, 7'd63));
    // Near misses on controller and on channel; slots still invalid hold a
    // zero key but must not answer.
    queue_item(cc_item(4'h0, 7'd1, 7'd10));
    queue_item(cc_item(4'h1, 7'd0, 7'd10));
    // Statuses that are not control changes.
    queue_item(midi_item(STAT_SYS_RESET, 7'd0, 7'd0));
    queue_item(midi_item(STAT_ZERO, 7'd127, 7'd127));
    queue_item(midi_item(STAT_POLY_TOUCH, 7'd0, 7'd127));
    queue_item(midi_item(STAT_PROGRAM, 7'd0, 7'd0));
    queue_item(learn_item(3'd2));
    queue_item(cc_item(4'h0, 7'd0, 7'd1));
    queue_item(cc_item(4'h0, 7'd0, 7'd127));

    // Random part. A small pool of keys keeps most control changes landing
    // on trained slots, so the fan-out path gets real work.
    for (int p = 0; p < 3; p++) begin
      pool_chan[p] = CHAN_W'($urandom_range(0, 15));
      pool_ctrl[p] = CTRL_W'($urandom_range(0, 127));
    end
    while (counted_items < TARGET_ITEMS) begin
      pick = $urandom_range(0, 4);
      if (pick < 3) begin
        chan = pool_chan[pick];
        ctrl = pool_ctrl[pick];
      end else begin
        chan = CHAN_W'($urandom_range(0, 15));
        ctrl = CTRL_W'($urandom_range(0, 127));
      end
      roll = $urandom_range(0, 99);
      if (roll < 28) begin
        queue_item(learn_item(SLOT_W'($urandom_range(0, NUM_SLOTS - 1))));
        queue_item(cc_item(chan, ctrl, VAL_W'($urandom_range(0, 127))));
      end else if (roll < 72) begin
        queue_item(cc_item(chan, ctrl, VAL_W'($urandom_range(0, 127))));
      end else if (roll < 77) begin
        queue_item(learn_item(SLOT_W'($urandom_range(0, NUM_SLOTS - 1))));
      end else if (roll < 87) begin
        queue_item(midi_item(STATUS_W'($urandom_range(0, 255)),
                             CTRL_W'($urandom_range(0, 127)),
                             VAL_W'($urandom_range(0, 127))));
      end else if (roll < 91) begin
        // Every slot trained on one key, then that key sent twice: eight words each.
        for (int s = 0; s < NUM_SLOTS; s++) begin
          queue_item(learn_item(SLOT_W'(s)));
          queue_item(cc_item(chan, ctrl, VAL_W'($urandom_range(0, 127))));
        end
        queue_item(cc_item(chan, ctrl, VAL_W'($urandom_range(0, 127))));
        queue_item(cc_item(chan, ctrl, VAL_W'($urandom_range(0, 127))));
      end else if (roll < 97) begin
        // Armed learning survives a message of another kind.
        queue_item(learn_item(SLOT_W'($urandom_range(0, NUM_SLOTS - 1))));
        queue_item(midi_item({4'($urandom_range(8, 10)), chan}, ctrl,
                             VAL_W'($urandom_range(0, 127))));
        queue_item(cc_item(chan, ctrl, VAL_W'($urandom_range(0, 127))));
      end else begin
        pool_chan[pick % 3] = CHAN_W'($urandom_range(0, 15));
        pool_ctrl[pick % 3] = CTRL_W'($urandom_range(0, 127));
      end
    end
    items_total = pending_items.size();

    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken != items_total) @(posedge clk);
    while (routed_words.size() != 0) @(posedge clk);
    // Room for any stray word the block might still put out.
    repeat (4 * NUM_SLOTS) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_midi_cc_learn_demux: PASS");
    end else begin
      $display("tb_midi_cc_learn_demux: FAIL");
    end
    $finish;
  end

  // Each time pace_count wraps, decide whether the next stretch runs without idling.
  always @(posedge clk) begin
    pace_count <= pace_count + 1'b1;
    if (pace_count == '0) begin
      calm_window <= ($urandom_range(0, 3) == 0);
    end
  end

  // Driver. A word that is offered stays put until it is taken; a new word
  // or an idle burst is chosen only when nothing is held.
  midi_item_t offered;
  int         send_gap = 0;

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        route_message(offered);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!tail_calm && !calm_window && $urandom_range(0, 5) == 0) begin
          // Idle burst of random length, drawn into send_gap.
          in_valid <= 1'b0;
          send_gap = $urandom_range(0, 5);
        end else begin
          offered = pending_items.pop_front();
          in_valid <= 1'b1;
          in_command <= offered.command;
          in_status_byte <= offered.status;
          in_controller_number <= offered.ctrl;
          in_value_byte <= offered.vbyte;
          in_learn_slot <= offered.lslot;
        end
      end
    end
    tail_calm <= pending_items.size() < TAIL_ITEMS;
  end

  // Monitor. Checks each routed word against the oldest one owed, then
  // picks the stall for the next cycle. Once, after a few dozen words, the
  // receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills and has to stall its own input.
  int recv_gap = 0;
  int hold_left = 0;
  int words_seen = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : monitor
    routed_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (routed_words.size() == 0) begin
          flag_mismatch($sformatf("unexpected word slot=%0d value=%0d last=%0b",
                                  out_slot, out_value, out_last));
        end else begin
          want = routed_words.pop_front();
          if (out_slot !== want.slot) begin
            flag_mismatch($sformatf("slot %0d, expected %0d", out_slot, want.slot));
          end
          if (out_value !== want.value) begin
            flag_mismatch($sformatf("value %0d, expected %0d (slot %0d)",
                                    out_value, want.value, want.slot));
          end
          if (out_last !== want.last) begin
            flag_mismatch($sformatf("last %0b, expected %0b (slot %0d)",
                                    out_last, want.last, want.slot));
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && words_seen >= 60) begin
        out_stall <= 1'b1;
        hold_left = LONG_HOLD - 1;
        hold_done = 1'b1;
      end else if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap--;
      end else if (!tail_calm && !calm_window && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        recv_gap = $urandom_range(0, 5);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too many cycles in a row without a handshake on either side
  // means the block has hung or lost a word.
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: no handshake for %0d cycles, %0d words still owed",
               quiet_cycles, routed_words.size());
      $display("tb_midi_cc_learn_demux: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
